### rtl/core/abs_pkg.sv
// ----------------------------------------------------------------------------
// abs_pkg
// Shared widths, constants and types of the adaptive background subtraction
// block: per-channel lane datapath, merge stage, result queue and top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package abs_pkg;

  // Pixel and lane geometry
  localparam int NUM_LANES  = 3;
  localparam int PIX_W      = 8;
  localparam int MAX_PIXELS = 131072;
  localparam int POS_W      = $clog2(MAX_PIXELS);
  localparam int FILL_W     = POS_W + 1;

  // Fixed point: statistics are Q8.16, rates Q0.16
  localparam int FRAC_W  = 16;
  localparam int Q_W     = PIX_W + FRAC_W;
  localparam int RATE_W  = FRAC_W;
  localparam int COEF_W  = RATE_W + 1;
  localparam int PROD_W  = Q_W + COEF_W;
  localparam int SUM_W   = PROD_W + 1;

  localparam logic [Q_W-1:0]    Q_MAX     = '1;
  localparam logic [COEF_W-1:0] SQRT2_Q16 = COEF_W'(92682);
  localparam logic [COEF_W-1:0] ONE_Q16   = COEF_W'(1) << RATE_W;

  // Configuration
  localparam int ZETA_W     = 8;
  localparam int FRM_W      = 8;
  localparam int CNT_W      = FRM_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZETA        = 3'd0,
    REG_BG_RATE     = 3'd1,
    REG_FG_RATE     = 3'd2,
    REG_INIT_FRAMES = 3'd3,
    REG_INIT_RECIP  = 3'd4
  } cfg_reg_t;

  localparam logic [ZETA_W-1:0] ZETA_RST        = ZETA_W'(15);
  localparam logic [RATE_W-1:0] BG_RATE_RST     = RATE_W'(1311);
  localparam logic [RATE_W-1:0] FG_RATE_RST     = RATE_W'(33);
  localparam logic [FRM_W-1:0]  INIT_FRAMES_RST = FRM_W'(50);
  localparam logic [RATE_W-1:0] INIT_RECIP_RST  = RATE_W'(1311);

  // Result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    PH_MEAN   = 2'd0,
    PH_SPREAD = 2'd1,
    PH_DETECT = 2'd2
  } phase_t;

  // Update pipeline depth, memory read to row write-back
  localparam int STAGES = 4;

  // Per-stage control carried alongside the lanes
  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] pos;
    phase_t           phase;
    logic             eof;
    logic             hit;
  } ctrl_t;

  // Update coefficients: new = (v*k + target*r) >> 16
  typedef struct packed {
    logic [COEF_W-1:0] km;
    logic [RATE_W-1:0] rm;
    logic [COEF_W-1:0] ks;
    logic [RATE_W-1:0] rs;
  } coef_t;

  typedef struct packed {
    logic [Q_W-1:0] mean;
    logic [Q_W-1:0] spread;
  } stat_t;

  typedef struct packed {
    logic             is_foreground;
    logic             in_training;
    logic [PIX_W-1:0] fg_blue;
    logic [PIX_W-1:0] fg_green;
    logic [PIX_W-1:0] fg_red;
    logic             frame_done;
  } result_t;

endpackage

### rtl/core/abs_if.sv
// ----------------------------------------------------------------------------
// abs_if
// Handshake channels of the background subtraction block: pixel input,
// result output and configuration write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface abs_pixel_if;
  logic                      valid;
  logic                      ready;
  logic [abs_pkg::PIX_W-1:0] blue;
  logic [abs_pkg::PIX_W-1:0] green;
  logic [abs_pkg::PIX_W-1:0] red;
  logic                      end_of_frame;

  modport source (output valid, blue, green, red, end_of_frame, input ready);
  modport sink   (input valid, blue, green, red, end_of_frame, output ready);
endinterface

interface abs_result_if;
  logic                      valid;
  logic                      ready;
  logic                      is_foreground;
  logic                      in_training;
  logic [abs_pkg::PIX_W-1:0] fg_blue;
  logic [abs_pkg::PIX_W-1:0] fg_green;
  logic [abs_pkg::PIX_W-1:0] fg_red;
  logic                      frame_done;

  modport source (output valid, is_foreground, in_training, fg_blue, fg_green,
                  fg_red, frame_done, input ready);
  modport sink   (input valid, is_foreground, in_training, fg_blue, fg_green,
                  fg_red, frame_done, output ready);
endinterface

interface abs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [abs_pkg::CFG_IDX_W-1:0]  index;
  logic [abs_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/abs_lane.sv
// ----------------------------------------------------------------------------
// abs_lane
// One colour channel: background statistics memory and the four-stage
// read, compare, multiply and write-back datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module abs_lane (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [abs_pkg::POS_W-1:0]   rd_addr,
  input  logic [abs_pkg::PIX_W-1:0]   x,
  input  logic                        hit,
  input  logic [abs_pkg::ZETA_W-1:0]  zeta,
  input  abs_pkg::coef_t              coef,
  input  logic                        wr_en,
  input  logic [abs_pkg::POS_W-1:0]   wr_addr,
  output logic                        fail,
  output logic [abs_pkg::PIX_W-1:0]   x_out
);
  import abs_pkg::*;

  function automatic logic [Q_W-1:0] sat_q(input logic [Q_W+1:0] v);
    return (|v[Q_W+1:Q_W]) ? Q_MAX : v[Q_W-1:0];
  endfunction

  stat_t mem [MAX_PIXELS];
  stat_t rd_q;

  // Stage registers
  logic [PIX_W-1:0]       x1, x2, x3, x4;
  logic [Q_W-1:0]         m2, s2, d2, m3, s3;
  logic [Q_W:0]           sz2;
  logic                   fail3;
  logic [PROD_W-1:0]      tprod3;
  logic [PROD_W-1:0]      pm1_4, ps1_4, ps2_4;
  logic [PIX_W+RATE_W-1:0] pm2_4;

  // Stage 1 signals
  logic [Q_W-1:0] m1, s1, xq1, d1;
  logic [Q_W:0]   sz1;
  // Stage 2 signals
  logic [Q_W+1:0]    xq2e, lo_sum, hi_sum;
  logic              fail2;
  logic [PROD_W-1:0] tprod2;
  // Stage 3 signals
  logic [Q_W-1:0]          t3;
  logic [PROD_W-1:0]       pm1_next, ps1_next, ps2_next;
  logic [PIX_W+RATE_W-1:0] pm2_next;
  // Stage 4 signals
  logic [SUM_W-1:0] mean_sum, spread_sum;
  stat_t            wr_data;

  // Statistics memory: one row per pixel position
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Stage 1: rows past the fill mark read as zero
  always_comb begin
    m1  = hit ? rd_q.mean   : '0;
    s1  = hit ? rd_q.spread : '0;
    xq1 = {x1, {FRAC_W{1'b0}}};
    d1  = (xq1 >= m1) ? (xq1 - m1) : (m1 - xq1);
    sz1 = {1'b0, s1} + {1'b0, zeta, {FRAC_W{1'b0}}};
  end

  // Stage 2: inclusive range test and sqrt2 scaling of the deviation
  always_comb begin
    xq2e   = {2'b00, x2, {FRAC_W{1'b0}}};
    lo_sum = xq2e + {1'b0, sz2};
    hi_sum = {2'b00, m2} + {1'b0, sz2};
    fail2  = (lo_sum < {2'b00, m2}) || (xq2e > hi_sum);
    tprod2 = PROD_W'(d2) * PROD_W'(SQRT2_Q16);
  end

  // Stage 3: weight mean and spread with the merged coefficients
  always_comb begin
    t3       = tprod3[PROD_W-1] ? Q_MAX : tprod3[PROD_W-2:FRAC_W];
    pm1_next = PROD_W'(m3) * PROD_W'(coef.km);
    pm2_next = (PIX_W+RATE_W)'(x3) * (PIX_W+RATE_W)'(coef.rm);
    ps1_next = PROD_W'(s3) * PROD_W'(coef.ks);
    ps2_next = PROD_W'(t3) * PROD_W'(coef.rs);
  end

  // Stage 4: sum, drop the fraction, saturate
  always_comb begin
    mean_sum       = SUM_W'(pm1_4) + {2'b00, pm2_4, {FRAC_W{1'b0}}};
    spread_sum     = SUM_W'(ps1_4) + SUM_W'(ps2_4);
    wr_data.mean   = sat_q(mean_sum[SUM_W-1:FRAC_W]);
    wr_data.spread = sat_q(spread_sum[SUM_W-1:FRAC_W]);
  end

  // Advance the lane pipeline every cycle
  always_ff @(posedge clk) begin
    x1     <= x;
    x2     <= x1;
    m2     <= m1;
    s2     <= s1;
    d2     <= d1;
    sz2    <= sz1;
    x3     <= x2;
    m3     <= m2;
    s3     <= s2;
    fail3  <= fail2;
    tprod3 <= tprod2;
    x4     <= x3;
    pm1_4  <= pm1_next;
    pm2_4  <= pm2_next;
    ps1_4  <= ps1_next;
    ps2_4  <= ps2_next;
  end

  assign fail  = fail3;
  assign x_out = x4;

endmodule

### rtl/core/abs_merge.sv
// ----------------------------------------------------------------------------
// abs_merge
// Combines the per-channel range tests into the foreground decision and
// picks the update coefficients that all lanes apply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module abs_merge (
  input  abs_pkg::phase_t               phase,
  input  logic [abs_pkg::NUM_LANES-1:0] fail,
  input  logic [abs_pkg::RATE_W-1:0]    bg_rate,
  input  logic [abs_pkg::RATE_W-1:0]    fg_rate,
  input  logic [abs_pkg::RATE_W-1:0]    init_recip,
  output logic                          fg,
  output abs_pkg::coef_t                coef
);
  import abs_pkg::*;

  // Foreground when any channel leaves its range, detection phase only
  assign fg = (phase == PH_DETECT) && (|fail);

  // Select what moves: mean, spread or both, and by how much
  always_comb begin
    coef.km = ONE_Q16;
    coef.rm = '0;
    coef.ks = ONE_Q16;
    coef.rs = '0;
    case (phase)
      PH_MEAN: begin
        coef.rm = init_recip;
      end
      PH_SPREAD: begin
        coef.rs = init_recip;
      end
      PH_DETECT: begin
        if (fg) begin
          coef.ks = ONE_Q16 - {1'b0, fg_rate};
          coef.rs = fg_rate;
        end else begin
          coef.km = ONE_Q16 - {1'b0, bg_rate};
          coef.rm = bg_rate;
          coef.ks = ONE_Q16 - {1'b0, bg_rate};
          coef.rs = bg_rate;
        end
      end
      default: begin
        coef.km = ONE_Q16;
      end
    endcase
  end

endmodule

### rtl/core/abs_out_fifo.sv
// ----------------------------------------------------------------------------
// abs_out_fifo
// Small result queue that decouples the non-stalling update pipeline from
// the output handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module abs_out_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  abs_pkg::result_t push_data,
  abs_result_if.source     results
);
  import abs_pkg::*;

  result_t            store [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;
  logic               pop;
  result_t            head;

  assign pop  = results.valid && results.ready;
  assign head = store[rd_ptr];

  // Capture results as they leave the pipeline; space is reserved upstream
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end
  end

  assign results.valid         = (count != '0);
  assign results.is_foreground = head.is_foreground;
  assign results.in_training   = head.in_training;
  assign results.fg_blue       = head.fg_blue;
  assign results.fg_green      = head.fg_green;
  assign results.fg_red        = head.fg_red;
  assign results.frame_done    = head.frame_done;

endmodule

### rtl/core/adaptive_background_subtraction_top.sv
// ----------------------------------------------------------------------------
// adaptive_background_subtraction_top
// Takes one three-channel pixel per clock and returns one result per pixel,
// in order. Three channel lanes run side by side, each with its own
// statistics memory (one mean/spread row per pixel position) and a
// four-stage read, compare, multiply, write-back pipeline; a merge stage
// turns the three range tests into the foreground flag. A result enters
// the result queue as its row is written back. The sustained rate is one
// pixel per cycle; a pixel whose position is still in flight in the update
// pipeline (position saturated at the end of the memory, or frames of four
// pixels or fewer) waits until that row is written back. An eight-entry
// result queue lets the input keep flowing while a result waits.
// Statistics need no clearing pass after reset: a fill mark records how far
// into the frame any pixel has reached, and rows beyond it read as zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adaptive_background_subtraction_top (
  input  logic         clk,
  input  logic         rst,
  abs_pixel_if.sink    pixels,
  abs_result_if.source results,
  abs_cfg_if.sink      cfg
);
  import abs_pkg::*;

  // Configuration registers
  logic [ZETA_W-1:0] zeta;
  logic [RATE_W-1:0] bg_rate;
  logic [RATE_W-1:0] fg_rate;
  logic [FRM_W-1:0]  init_frames;
  logic [RATE_W-1:0] init_recip;

  // Frame state
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  pos_next;
  logic [FILL_W-1:0] fill;
  logic [CNT_W-1:0]  count;
  phase_t            phase;

  // Pipeline control
  ctrl_t             st [STAGES];
  ctrl_t             st0_next;
  logic              hazard;
  logic              in_xfer;
  logic              out_xfer;
  logic [FIFO_AW:0]  outstanding;
  logic              fg;
  logic              fg_s4;
  coef_t             coef;

  logic [PIX_W-1:0]     lane_x  [NUM_LANES];
  logic [PIX_W-1:0]     lane_x4 [NUM_LANES];
  logic [NUM_LANES-1:0] lane_fail;
  result_t              res;

  // Accept configuration at any time
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      zeta        <= ZETA_RST;
      bg_rate     <= BG_RATE_RST;
      fg_rate     <= FG_RATE_RST;
      init_frames <= INIT_FRAMES_RST;
      init_recip  <= INIT_RECIP_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ZETA:        zeta        <= cfg.data[ZETA_W-1:0];
        REG_BG_RATE:     bg_rate     <= cfg.data[RATE_W-1:0];
        REG_FG_RATE:     fg_rate     <= cfg.data[RATE_W-1:0];
        REG_INIT_FRAMES: init_frames <= cfg.data[FRM_W-1:0];
        REG_INIT_RECIP:  init_recip  <= cfg.data[RATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Training phase from the frame count
  always_comb begin
    if (count < {1'b0, init_frames}) begin
      phase = PH_MEAN;
    end else if (count < {init_frames, 1'b0}) begin
      phase = PH_SPREAD;
    end else begin
      phase = PH_DETECT;
    end
  end

  // Hold off a pixel whose row is still being updated
  always_comb begin
    hazard = 1'b0;
    for (int i = 0; i < STAGES; i++) begin
      if (st[i].valid && (st[i].pos == pos)) begin
        hazard = 1'b1;
      end
    end
  end

  assign pixels.ready = !rst && !hazard && (outstanding < (FIFO_AW+1)'(FIFO_DEPTH));
  assign in_xfer      = pixels.valid && pixels.ready;
  assign out_xfer     = results.valid && results.ready;

  // Next raster position, saturating at the last row
  always_comb begin
    if (pixels.end_of_frame) begin
      pos_next = '0;
    end else if (pos != POS_W'(MAX_PIXELS - 1)) begin
      pos_next = pos + 1'b1;
    end else begin
      pos_next = pos;
    end
  end

  // Advance position, fill mark, frame count and transfer credit
  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      fill        <= '0;
      count       <= '0;
      outstanding <= '0;
    end else begin
      if (in_xfer) begin
        pos <= pos_next;
        if ({1'b0, pos} == fill) begin
          fill <= fill + 1'b1;
        end
        if (pixels.end_of_frame && (phase != PH_DETECT)) begin
          count <= count + 1'b1;
        end
      end
      outstanding <= outstanding + (FIFO_AW+1)'(in_xfer) - (FIFO_AW+1)'(out_xfer);
    end
  end

  // Control stage entering alongside the memory read
  always_comb begin
    st0_next.valid = in_xfer;
    st0_next.pos   = pos;
    st0_next.phase = phase;
    st0_next.eof   = pixels.end_of_frame;
    st0_next.hit   = ({1'b0, pos} < fill);
  end

  always_ff @(posedge clk) begin
    fg_s4 <= fg;
    if (rst) begin
      for (int i = 0; i < STAGES; i++) begin
        st[i].valid <= 1'b0;
      end
    end else begin
      st[0] <= st0_next;
      for (int i = 1; i < STAGES; i++) begin
        st[i] <= st[i-1];
      end
    end
  end

  // Channel lanes
  assign lane_x[0] = pixels.blue;
  assign lane_x[1] = pixels.green;
  assign lane_x[2] = pixels.red;

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    abs_lane u_lane (
      .clk     (clk),
      .rd_en   (in_xfer),
      .rd_addr (pos),
      .x       (lane_x[l]),
      .hit     (st[0].hit),
      .zeta    (zeta),
      .coef    (coef),
      .wr_en   (st[STAGES-1].valid),
      .wr_addr (st[STAGES-1].pos),
      .fail    (lane_fail[l]),
      .x_out   (lane_x4[l])
    );
  end

  // Merge the lane range tests in stage three
  abs_merge u_merge (
    .phase      (st[2].phase),
    .fail       (lane_fail),
    .bg_rate    (bg_rate),
    .fg_rate    (fg_rate),
    .init_recip (init_recip),
    .fg         (fg),
    .coef       (coef)
  );

  // Build the result as the row is written back
  always_comb begin
    res.is_foreground = fg_s4;
    res.in_training   = (st[STAGES-1].phase != PH_DETECT);
    res.fg_blue       = fg_s4 ? lane_x4[0] : '0;
    res.fg_green      = fg_s4 ? lane_x4[1] : '0;
    res.fg_red        = fg_s4 ? lane_x4[2] : '0;
    res.frame_done    = st[STAGES-1].eof;
  end

  abs_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (st[STAGES-1].valid),
    .push_data (res),
    .results   (results)
  );

endmodule

### dv/adaptive_background_subtraction_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_background_subtraction_top_tb
// Self-checking bench for the background subtraction block. A short directed
// list covers reset defaults, field extremes, the training phases, zero
// rates, single-pixel frames and register changes. Training statistics that
// are resumed after a register change are covered too. Random scene-based
// frames follow. Every result is compared against a directed expectation or
// an in-bench model of the per-pixel statistics.
// ----------------------------------------------------------------------------

module adaptive_background_subtraction_top_tb;
  import abs_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int DRAIN_TAIL  = 8;
  localparam int END_TAIL    = 20;
  localparam int LONG_HOLD   = 80;
  localparam int SCENE_PIX   = 16;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic             eof;
  } pixel_t;

  typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    cfg_reg_t    idx;
    int unsigned value;
    pixel_t      pix;
    bit          typed;
    result_t     want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;

  abs_pixel_if  pix_ch ();
  abs_result_if res_ch ();
  abs_cfg_if    cfg_ch ();

  adaptive_background_subtraction_top dut (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pix_ch),
    .results (res_ch),
    .cfg     (cfg_ch)
  );

  always #5 clk = ~clk;

  // Model state: per-pixel statistics, position, frame count, registers
  bit [Q_W-1:0]    bg_mean   [NUM_LANES*MAX_PIXELS];
  bit [Q_W-1:0]    bg_spread [NUM_LANES*MAX_PIXELS];
  int unsigned     pix_pos;
  bit [CNT_W-1:0]  train_cnt;
  bit [ZETA_W-1:0] zeta_cfg        = ZETA_RST;
  bit [RATE_W-1:0] bg_rate_cfg     = BG_RATE_RST;
  bit [RATE_W-1:0] fg_rate_cfg     = FG_RATE_RST;
  bit [FRM_W-1:0]  init_frames_cfg = INIT_FRAMES_RST;
  bit [RATE_W-1:0] init_recip_cfg  = INIT_RECIP_RST;

  result_t     pending_results[$];
  plan_row_t   plan[$];
  bit [7:0]    scene [SCENE_PIX][NUM_LANES];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned cycle_cnt;
  bit          steady;
  bit          stall_req;

  function automatic bit [Q_W-1:0] sat_q(bit [63:0] v);
    return (v > 64'(Q_MAX)) ? Q_MAX : v[Q_W-1:0];
  endfunction

  function automatic bit [Q_W-1:0] blend_q(bit [Q_W-1:0] v, bit [Q_W-1:0] target,
                                           bit [RATE_W-1:0] rate);
    bit [63:0] acc;
    acc = 64'(v) * (64'd65536 - 64'(rate)) + 64'(target) * 64'(rate);
    return sat_q(acc >> 16);
  endfunction

  // Classify one pixel and update the stored statistics
  function automatic result_t classify_pixel(pixel_t p);
    bit [7:0]     x [NUM_LANES];
    bit [Q_W-1:0] t [NUM_LANES];
    bit [63:0]    xq, m, s, z, d, add;
    int unsigned  base;
    int           c;
    phase_t       ph;
    bit           fg;
    result_t      r;
    x[0] = p.blue;
    x[1] = p.green;
    x[2] = p.red;
    base = pix_pos * NUM_LANES;
    fg   = 1'b0;
    if (int'(train_cnt) < int'(init_frames_cfg)) ph = PH_MEAN;
    else if (int'(train_cnt) < 2 * int'(init_frames_cfg)) ph = PH_SPREAD;
    else ph = PH_DETECT;

    for (c = 0; c < NUM_LANES; c++) begin
      xq   = 64'(x[c]) << FRAC_W;
      m    = 64'(bg_mean[base+c]);
      d    = (xq >= m) ? xq - m : m - xq;
      t[c] = sat_q((d * 64'(SQRT2_Q16)) >> FRAC_W);
    end

    case (ph)
      PH_MEAN: begin
        for (c = 0; c < NUM_LANES; c++) begin
          add = ((64'(x[c]) << FRAC_W) * 64'(init_recip_cfg)) >> FRAC_W;
          bg_mean[base+c] = sat_q(64'(bg_mean[base+c]) + add);
        end
      end
      PH_SPREAD: begin
        for (c = 0; c < NUM_LANES; c++) begin
          add = (64'(t[c]) * 64'(init_recip_cfg)) >> FRAC_W;
          bg_spread[base+c] = sat_q(64'(bg_spread[base+c]) + add);
        end
      end
      default: begin
        z = 64'(zeta_cfg) << FRAC_W;
        for (c = 0; c < NUM_LANES; c++) begin
          xq = 64'(x[c]) << FRAC_W;
          m  = 64'(bg_mean[base+c]);
          s  = 64'(bg_spread[base+c]);
          if (xq + s + z < m || xq > m + s + z) fg = 1'b1;
        end
        for (c = 0; c < NUM_LANES; c++) begin
          if (fg) begin
            bg_spread[base+c] = blend_q(bg_spread[base+c], t[c], fg_rate_cfg);
          end else begin
            bg_mean[base+c]   = blend_q(bg_mean[base+c], Q_W'(x[c]) << FRAC_W,
                                        bg_rate_cfg);
            bg_spread[base+c] = blend_q(bg_spread[base+c], t[c], bg_rate_cfg);
          end
        end
      end
    endcase

    r.is_foreground = fg;
    r.in_training   = (ph != PH_DETECT);
    r.fg_blue       = fg ? x[0] : '0;
    r.fg_green      = fg ? x[1] : '0;
    r.fg_red        = fg ? x[2] : '0;
    r.frame_done    = p.eof;

    // Advance position; count training frames at frame end
    if (p.eof) begin
      pix_pos = 0;
      if (ph != PH_DETECT && int'(train_cnt) < 2 * int'(init_frames_cfg))
        train_cnt = train_cnt + 1'b1;
    end else if (pix_pos < MAX_PIXELS - 1) begin
      pix_pos++;
    end
    return r;
  endfunction

  function automatic plan_row_t pix_row(bit [7:0] b, bit [7:0] g, bit [7:0] r, bit eof,
                                        bit typed, bit want_fg, bit want_train);
    plan_row_t row;
    row.kind = ROW_PIXEL;
    row.idx  = REG_ZETA;
    row.value = 0;
    row.pix  = '{blue: b, green: g, red: r, eof: eof};
    row.typed = typed;
    row.want = '{is_foreground: want_fg, in_training: want_train,
                 fg_blue: want_fg ? b : 8'd0, fg_green: want_fg ? g : 8'd0,
                 fg_red: want_fg ? r : 8'd0, frame_done: eof};
    return row;
  endfunction

  function automatic plan_row_t reg_row(cfg_reg_t idx, int unsigned value);
    plan_row_t row;
    row = pix_row(8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    row.kind  = ROW_REG;
    row.idx   = idx;
    row.value = value;
    return row;
  endfunction

  // Append one row to the directed plan
  task automatic plan_add(plan_row_t row);
    plan.insert(plan.size(), row);
  endtask

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  function automatic int unsigned pick_rate();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 16'hFFFF;
      default: return $urandom_range(0, 16'hFFFF);
    endcase
  endfunction

  function automatic bit [7:0] pick_channel(bit [7:0] base);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      v = int'(base) + $urandom_range(0, 6) - 3;
      return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
    end
    if (r < 90) return 8'($urandom_range(0, 255));
    return $urandom_range(0, 1) ? 8'd255 : 8'd0;
  endfunction

  // Hold the pixel channel low until every expected result has arrived
  task automatic wait_drained();
    pix_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Offer one pixel, predict its result on transfer; called at a falling edge
  task automatic send_pixel(pixel_t p, bit typed, result_t want);
    int      gap;
    result_t predicted;
    gap = (steady || $urandom_range(0, 99) >= 30) ? 0 : pick_gap();
    if (gap > 0) begin
      pix_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_ch.valid        = 1'b1;
    pix_ch.blue         = p.blue;
    pix_ch.green        = p.green;
    pix_ch.red          = p.red;
    pix_ch.end_of_frame = p.eof;
    do @(posedge clk); while (!pix_ch.ready);
    predicted = classify_pixel(p);
    pending_results.insert(pending_results.size(), typed ? want : predicted);
    @(negedge clk);
  endtask

  // Write one register with the block idle
  task automatic write_reg(cfg_reg_t idx, int unsigned value);
    wait_drained();
    repeat (DRAIN_TAIL) @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_ZETA:        zeta_cfg        = value[ZETA_W-1:0];
      REG_BG_RATE:     bg_rate_cfg     = value[RATE_W-1:0];
      REG_FG_RATE:     fg_rate_cfg     = value[RATE_W-1:0];
      REG_INIT_FRAMES: init_frames_cfg = value[FRM_W-1:0];
      REG_INIT_RECIP:  init_recip_cfg  = value[RATE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_detect(int unsigned zeta, int unsigned bg, int unsigned fg);
    write_reg(REG_ZETA, zeta);
    write_reg(REG_BG_RATE, bg);
    write_reg(REG_FG_RATE, fg);
  endtask

  // Stream whole frames of scene pixels; frame_len of zero picks per frame
  task automatic run_frames(int n_items, int frame_len);
    int     sent;
    int     len;
    int     k;
    pixel_t p;
    sent = 0;
    while (sent < n_items) begin
      len = (frame_len > 0) ? frame_len : $urandom_range(1, 12);
      for (k = 0; k < len; k++) begin
        p.blue  = pick_channel(scene[k][0]);
        p.green = pick_channel(scene[k][1]);
        p.red   = pick_channel(scene[k][2]);
        p.eof   = (k == len - 1);
        send_pixel(p, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // Result side: random ready gaps, plus one long hold-off on request
  initial begin : result_sink
    int sink_gap;
    sink_gap     = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        res_ch.ready = 1'b0;
      end else if (stall_req) begin
        stall_req    = 1'b0;
        res_ch.ready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (sink_gap > 0) begin
        res_ch.ready = 1'b0;
        sink_gap--;
      end else begin
        res_ch.ready = 1'b1;
        if (!steady && $urandom_range(0, 99) < 25) sink_gap = pick_gap();
      end
    end
  end

  task automatic note_mismatch(string field, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("result %0d: %s expected %0d, got %0d", results_seen, field, want, got);
  endtask

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: transfer with no result pending", results_seen);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (res_ch.is_foreground !== want.is_foreground)
          note_mismatch("is_foreground", want.is_foreground, res_ch.is_foreground);
        if (res_ch.in_training !== want.in_training)
          note_mismatch("in_training", want.in_training, res_ch.in_training);
        if (res_ch.fg_blue !== want.fg_blue)
          note_mismatch("fg_blue", want.fg_blue, res_ch.fg_blue);
        if (res_ch.fg_green !== want.fg_green)
          note_mismatch("fg_green", want.fg_green, res_ch.fg_green);
        if (res_ch.fg_red !== want.fg_red)
          note_mismatch("fg_red", want.fg_red, res_ch.fg_red);
        if (res_ch.frame_done !== want.frame_done)
          note_mismatch("frame_done", want.frame_done, res_ch.frame_done);
      end
      results_seen++;
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("adaptive_background_subtraction_top verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    plan_row_t   row;
    int unsigned frames;
    int          i;
    int          c;
    rst                 = 1'b1;
    pix_ch.valid        = 1'b0;
    pix_ch.blue         = '0;
    pix_ch.green        = '0;
    pix_ch.red          = '0;
    pix_ch.end_of_frame = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = REG_ZETA;
    cfg_ch.data         = '0;
    steady              = 1'b0;
    stall_req           = 1'b0;
    mismatches          = 0;
    results_seen        = 0;
    cycle_cnt           = 0;
    pix_pos             = 0;
    train_cnt           = '0;
    for (i = 0; i < SCENE_PIX; i++)
      for (c = 0; c < NUM_LANES; c++) scene[i][c] = 8'($urandom_range(0, 255));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset defaults: first training phase
    plan_add(pix_row(8'd0, 8'd0, 8'd0, 1'b0, 1'b1, 1'b0, 1'b1));
    plan_add(pix_row(8'd255, 8'd255, 8'd255, 1'b0, 1'b1, 1'b0, 1'b1));
    plan_add(pix_row(8'hAA, 8'h55, 8'h0F, 1'b1, 1'b1, 1'b0, 1'b1));
    // No training frames: detection from the first pixel
    plan_add(reg_row(REG_INIT_FRAMES, 0));
    plan_add(pix_row(8'd255, 8'd0, 8'd0, 1'b0, 1'b1, 1'b1, 1'b0));
    plan_add(pix_row(8'd0, 8'd0, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0));
    plan_add(pix_row(8'd15, 8'd15, 8'd15, 1'b1, 1'b1, 1'b0, 1'b0));
    plan_add(reg_row(REG_ZETA, 0));
    plan_add(pix_row(8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    plan_add(reg_row(REG_BG_RATE, 16'hFFFF));
    plan_add(reg_row(REG_FG_RATE, 0));
    plan_add(reg_row(REG_INIT_RECIP, 16'hFFFF));
    plan_add(pix_row(8'd255, 8'd255, 8'd255, 1'b1, 1'b0, 1'b0, 1'b0));
    // Back-to-back single-pixel frames on one position
    plan_add(pix_row(8'd128, 8'd128, 8'd128, 1'b1, 1'b0, 1'b0, 1'b0));
    plan_add(pix_row(8'd128, 8'd128, 8'd128, 1'b1, 1'b0, 1'b0, 1'b0));
    // Zero background rate, full foreground rate, widest margin
    plan_add(reg_row(REG_BG_RATE, 0));
    plan_add(reg_row(REG_FG_RATE, 16'hFFFF));
    plan_add(reg_row(REG_ZETA, 255));
    plan_add(pix_row(8'd3, 8'd200, 8'd77, 1'b1, 1'b0, 1'b0, 1'b0));
    plan_add(pix_row(8'd3, 8'd200, 8'd77, 1'b1, 1'b0, 1'b0, 1'b0));
    // Raising the frame count resumes training in the spread phase
    plan_add(reg_row(REG_INIT_FRAMES, 1));
    plan_add(pix_row(8'd1, 8'd2, 8'd4, 1'b1, 1'b1, 1'b0, 1'b1));
    plan_add(pix_row(8'd8, 8'd16, 8'd32, 1'b0, 1'b0, 1'b0, 1'b0));
    plan_add(reg_row(REG_INIT_FRAMES, 255));
    plan_add(reg_row(REG_INIT_RECIP, 1));
    plan_add(pix_row(8'd64, 8'd128, 8'd255, 1'b1, 1'b1, 1'b0, 1'b1));
    plan_add(pix_row(8'd0, 8'd255, 8'd0, 1'b1, 1'b1, 1'b0, 1'b1));

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_REG) write_reg(row.idx, row.value);
      else send_pixel(row.pix, row.typed, row.want);
    end

    // Fresh training run on the scene, then detection
    frames = int'(train_cnt) + 2;
    write_reg(REG_INIT_FRAMES, frames);
    write_reg(REG_INIT_RECIP, 32768);
    set_detect(15, 1311, 33);
    run_frames(90, 6);

    set_detect($urandom_range(5, 40), $urandom_range(0, 4000), $urandom_range(0, 200));
    run_frames(45, 0);

    // No idling at either side
    steady = 1'b1;
    set_detect(255, 16'hFFFF, pick_rate());
    run_frames(45, 8);
    steady = 1'b0;

    // Long receiver hold-off while pixels keep coming
    set_detect(0, pick_rate(), 16'hFFFF);
    stall_req = 1'b1;
    run_frames(45, 5);

    set_detect($urandom_range(0, 255), pick_rate(), pick_rate());
    run_frames(45, 0);

    // Resume training part way through the spread phase
    frames = int'(train_cnt) / 2 + 1;
    write_reg(REG_INIT_FRAMES, (frames > 255) ? 255 : frames);
    write_reg(REG_INIT_RECIP, $urandom_range(1, 16'hFFFF));
    run_frames(45, 4);

    // Sender pauses until everything has come back
    set_detect($urandom_range(0, 255), 0, 0);
    run_frames(20, 0);
    wait_drained();
    run_frames(25, 0);

    set_detect(15, pick_rate(), pick_rate());
    run_frames(40, 1);

    set_detect($urandom_range(0, 255), pick_rate(), pick_rate());
    write_reg(REG_INIT_RECIP, pick_rate() | 1);
    run_frames(45, 0);

    set_detect(15, BG_RATE_RST, FG_RATE_RST);
    run_frames(20, 0);

    wait_drained();
    repeat (END_TAIL) @(negedge clk);
    if (mismatches == 0) begin
      $display("adaptive_background_subtraction_top verification clean");
    end else begin
      $display("adaptive_background_subtraction_top verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/abs_pkg.sv
rtl/core/abs_if.sv
rtl/core/abs_lane.sv
rtl/core/abs_merge.sv
rtl/core/abs_out_fifo.sv
rtl/core/adaptive_background_subtraction_top.sv
dv/adaptive_background_subtraction_top_tb.sv
